/* hw/rtl/mexp_pkg.sv */
package mexp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_TEST,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

    // what the shared multiply/reduce unit is doing
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_MUL,
        OP_SQR
    } t_op;

    typedef struct packed {
        logic load;      // take a new item and start reducing the base
        logic step;      // one bit of the running operation
        logic start;     // restart the unit with start_op
        t_op  start_op;
        logic wb_acc;    // product into accumulator
        logic wb_base;   // product into base
        logic exp_shift; // drop the exponent bit just used
        logic out_load;  // accumulator into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last;
        logic exp_zero;
        logic exp_lsb;
        logic out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/mexp_ctrl.sv */
module mexp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mexp_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output mexp_pkg::t_dp_cmd o_cmd
);
    import mexp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.start_op = OP_MUL;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.step = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.wb_base = 1'b1;
                    n_state       = ST_TEST;
                end
            end
            ST_TEST: begin
                priority if (i_sts.exp_zero) begin
                    n_state = ST_DONE;
                end else if (i_sts.exp_lsb) begin
                    o_cmd.start    = 1'b1;
                    o_cmd.start_op = OP_MUL;
                    n_state        = ST_MUL;
                end else begin
                    o_cmd.start    = 1'b1;
                    o_cmd.start_op = OP_SQR;
                    n_state        = ST_SQR;
                end
            end
            ST_MUL: begin
                o_cmd.step = 1'b1;
                if (i_sts.cnt_last) begin
                    // squaring reads the base, which the multiply left unchanged
                    o_cmd.wb_acc   = 1'b1;
                    o_cmd.start    = 1'b1;
                    o_cmd.start_op = OP_SQR;
                    n_state        = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.step = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.wb_base   = 1'b1;
                    o_cmd.exp_shift = 1'b1;
                    n_state         = ST_TEST;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/mexp_dp.sv */
module mexp_dp #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [DATA_WIDTH-1:0] i_cfg_wr_data,
    input  logic [DATA_WIDTH-1:0] i_base_value,
    input  logic [DATA_WIDTH-1:0] i_exponent,
    input  logic                  i_out_ready,
    input  mexp_pkg::t_dp_cmd     i_cmd,
    output mexp_pkg::t_dp_sts     o_sts,
    output logic                  o_out_valid,
    output logic [DATA_WIDTH-1:0] o_power_result
);
    import mexp_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic [63:0] ModReset = 64'd1000000007;

    logic [DATA_WIDTH-1:0] r_mod;
    logic [DATA_WIDTH-1:0] r_m;
    logic [DATA_WIDTH-1:0] r_base;
    logic [DATA_WIDTH-1:0] r_exp;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_prod;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_mb;
    logic [CW-1:0]         r_cnt;
    t_op                   r_op;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_data;

    logic                  mod_is_one;
    logic [DATA_WIDTH-1:0] eff_mod;
    logic                  mb_msb;
    logic [DATA_WIDTH:0]   dbl;
    logic [DATA_WIDTH-1:0] red1;
    logic [DATA_WIDTH-1:0] addend;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH-1:0] n_prod;

    // a zero modulus behaves as one
    assign mod_is_one = (r_mod[DATA_WIDTH-1:1] == '0);
    assign eff_mod    = mod_is_one ? DATA_WIDTH'(1) : r_mod;

    // double, bring in a dividend bit when reducing, then add the multiplicand
    assign mb_msb = r_mb[DATA_WIDTH-1];
    assign dbl    = {r_prod, (r_op == OP_REDUCE) ? mb_msb : 1'b0};
    assign red1   = (dbl >= {1'b0, r_m}) ? DATA_WIDTH'(dbl - {1'b0, r_m})
                                         : dbl[DATA_WIDTH-1:0];
    assign addend = ((r_op != OP_REDUCE) && mb_msb) ? r_a : '0;
    assign sum    = {1'b0, red1} + {1'b0, addend};
    assign n_prod = (sum >= {1'b0, r_m}) ? DATA_WIDTH'(sum - {1'b0, r_m})
                                         : sum[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= ModReset[DATA_WIDTH-1:0];
            r_cnt       <= '0;
            r_op        <= OP_REDUCE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mod <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_m    <= eff_mod;
                r_base <= i_base_value;
                r_exp  <= i_exponent;
                // a zero exponent gives 1 even for a modulus of one
                r_acc  <= (mod_is_one && (i_exponent != '0)) ? '0 : DATA_WIDTH'(1);
                r_prod <= '0;
                r_mb   <= i_base_value;
                r_cnt  <= '0;
                r_op   <= OP_REDUCE;
            end else if (i_cmd.start) begin
                // a restart on the last bit of an operation replaces its step
                r_prod <= '0;
                r_cnt  <= '0;
                r_op   <= i_cmd.start_op;
                r_mb   <= r_base;
                r_a    <= (i_cmd.start_op == OP_MUL) ? r_acc : r_base;
            end else if (i_cmd.step) begin
                r_prod <= n_prod;
                r_mb   <= r_mb << 1;
                r_cnt  <= r_cnt + CW'(1);
            end
            if (i_cmd.wb_acc) begin
                r_acc <= n_prod;
            end
            if (i_cmd.wb_base) begin
                r_base <= n_prod;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= r_exp >> 1;
            end
            if (i_cmd.out_load) begin
                r_out_data  <= r_acc;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.cnt_last = (r_cnt == CW'(DATA_WIDTH - 1));
    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out_data;

endmodule

/* hw/rtl/modular_exponentiation.sv */
// Modular exponentiation: power_result = base_value ** exponent mod modulus.
// Input channel s_axis_*: one item holds base_value and exponent. Output
// channel m_axis_*: one item per input item, holding power_result, in order.
// The modulus is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce. A
// written zero acts as a modulus of one. A zero exponent always returns 1.
// The base is first reduced modulo the modulus; then, for each exponent
// bit up to the top set bit, a test, a multiply for a set bit and a squaring;
// then a final test and a load of the output register. This all runs on the
// one shared double-and-add unit, which retires one multiplier bit per cycle.
// One item is in work at a time; s_axis_tready is high only when idle, from
// the cycle after the result register loads.
// A finished result waits in the output register while the next item is
// taken; if the receiver still stalls when that item is done, the block
// holds it until the register frees.
// Reset (i_rst_n low, synchronous) empties the output register, returns to
// idle and sets the modulus to 1000000007.
module modular_exponentiation #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [DATA_WIDTH-1:0]                 i_cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // base_value, exponent
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // power_result
    output logic [((DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);
    import mexp_pkg::*;

    localparam int OutTw = ((DATA_WIDTH + 7) / 8) * 8;

    t_dp_cmd               cmd;
    t_dp_sts               sts;
    logic [DATA_WIDTH-1:0] power_result;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    mexp_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_base_value   (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_exponent     (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .i_out_ready    (m_axis_tready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (m_axis_tvalid),
        .o_power_result (power_result)
    );

    assign m_axis_tdata = OutTw'(power_result);

endmodule

/* hw/rtl/mexp_chk.sv */
module mexp_chk #(
    parameter int DATA_WIDTH = 31
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after an item");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without work");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not empty the block");

endmodule

bind modular_exponentiation mexp_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_mexp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
